/* hw/rtl/xmodem_crc_sender_macros.svh */
// Assertion macros for the XMODEM-CRC sender.
`ifndef XMODEM_CRC_SENDER_MACROS_SVH
`define XMODEM_CRC_SENDER_MACROS_SVH

// Clocked assertion, held off during reset.
`define XCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define XCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/xcs_pkg.sv */
// Package: constants and codes of the XMODEM-CRC sender.
`default_nettype none
package xcs_pkg;
  localparam int unsigned BufferBytes = 1024;
  localparam int unsigned SmallBlock  = 128;
  localparam int unsigned CntW        = 11;

  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChPad = 8'h1A;
  localparam logic [7:0] ChC   = 8'h43;

  localparam logic [2:0] OpBegin = 3'd0;
  localparam logic [2:0] OpData  = 3'd1;
  localparam logic [2:0] OpRx    = 3'd2;
  localparam logic [2:0] OpSlot  = 3'd3;
  localparam logic [2:0] OpTick  = 3'd4;

  localparam logic [3:0] StNone     = 4'd0;
  localparam logic [3:0] StRefused  = 4'd1;
  localparam logic [3:0] StStarted  = 4'd2;
  localparam logic [3:0] StAcked    = 4'd3;
  localparam logic [3:0] StRetry    = 4'd4;
  localparam logic [3:0] StComplete = 4'd5;
  localparam logic [3:0] StStartTo  = 4'd6;
  localparam logic [3:0] StCsumRef  = 4'd7;
  localparam logic [3:0] StCancel   = 4'd8;
  localparam logic [3:0] StExhaust  = 4'd9;
  localparam logic [3:0] StEotTo    = 4'd10;

  localparam logic [2:0] RegUse1k    = 3'd0;
  localparam logic [2:0] RegTimeout  = 3'd1;
  localparam logic [2:0] RegStartTo  = 3'd2;
  localparam logic [2:0] RegRetries  = 3'd3;
  localparam logic [2:0] RegFlash    = 3'd4;

  // One byte step of CRC-16, polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/xmodem_crc_sender.sv */
// Top level: XMODEM-CRC sender with block buffer memory and APB registers.
// Items pass the first-stage and output registers, one per cycle unless the
// result stream stalls; the block memory read and the one-byte CRC update in
// the second stage set the pace, with a registered read in between.
// Reset: asynchronous, active low; control state and registers take their
// defaults, the block memory is not cleared (entries are written before use).
`default_nettype none
`include "xmodem_crc_sender_macros.svh"
module xmodem_crc_sender
  import xcs_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BufferBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // byte_value
  input  wire logic [2:0]  s_tuser,   // operation
  input  wire logic        s_tlast,   // last_byte
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] tx_valid, [8:1] tx_byte, [12:9] status, [20:13] block_number,
  // [28:21] attempt_count, [29] finished, [31:30] zero
  output logic      [31:0] m_tdata
);
  localparam int unsigned AddrW = $clog2(BUFFER_BYTES);

  typedef enum logic [3:0] {
    PhIdle, PhWaitStart, PhFill, PhDelay, PhSend, PhWaitResp, PhEotSend,
    PhEotWait, PhDone
  } phase_e;

  typedef enum logic [2:0] {
    KNone, KConst, KMem, KPad, KCrcHi, KCrcLo
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] cbyte;
    logic       crc_clr;
    logic [3:0] status;
    logic [7:0] seq;
    logic [7:0] att;
    logic       fin;
  } s1_t;

  // ---------------- configuration registers
  logic        use_1k_q;
  logic [15:0] timeout_q, start_to_q;
  logic [7:0]  retries_q, flash_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_1k_q   <= 1'b1;
      timeout_q  <= 16'd15000;
      start_to_q <= 16'd60000;
      retries_q  <= 8'd10;
      flash_q    <= 8'd10;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegUse1k:   use_1k_q   <= pwdata[0];
        RegTimeout: timeout_q  <= pwdata[15:0];
        RegStartTo: start_to_q <= pwdata[15:0];
        RegRetries: retries_q  <= pwdata[7:0];
        RegFlash:   flash_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegUse1k:   prdata = {31'd0, use_1k_q};
      RegTimeout: prdata = {16'd0, timeout_q};
      RegStartTo: prdata = {16'd0, start_to_q};
      RegRetries: prdata = {24'd0, retries_q};
      RegFlash:   prdata = {24'd0, flash_q};
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------- control state (first stage)
  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   fill_q, fill_d, pos_q, pos_d;
  logic              final_q, final_d;
  logic [7:0]        seq_q, seq_d, att_q, att_d;
  logic [15:0]       timer_q, timer_d;

  logic              s1_v_q, adv, in_acc;
  s1_t               s1_q, s1_d;
  logic              out_v_q;
  logic [29:0]       out_q;
  logic [15:0]       crc_q;

  logic [7:0]        mem [BUFFER_BYTES];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  rd_addr;

  assign adv      = !out_v_q || m_tready;
  assign s_tready = !s1_v_q || adv;
  assign in_acc   = s_tvalid && s_tready;

  logic [CntW-1:0] bsize, idx;
  logic            ready_blk;
  assign bsize     = use_1k_q ? CntW'(BUFFER_BYTES) : CntW'(SmallBlock);
  assign ready_blk = final_q || (fill_q >= bsize);
  assign idx       = pos_q - CntW'(3);
  assign rd_addr   = idx[AddrW-1:0];

  always_comb begin
    logic [15:0] limit;
    logic [15:0] tinc;
    logic        fail, start_pk, to_fill;
    phase_d = phase_q;
    fill_d  = fill_q;
    final_d = final_q;
    pos_d   = pos_q;
    seq_d   = seq_q;
    att_d   = att_q;
    timer_d = timer_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    fail     = 1'b0;
    start_pk = 1'b0;
    to_fill  = 1'b0;
    limit    = timeout_q;
    tinc     = (timer_q != 16'hFFFF) ? timer_q + 16'd1 : timer_q;
    s1_d         = '0;
    s1_d.kind    = KNone;
    s1_d.status  = StNone;

    case (s_tuser)
      OpBegin: begin
        if (phase_q == PhIdle || phase_q == PhDone) begin
          phase_d      = PhWaitStart;
          timer_d      = '0;
          fill_d       = '0;
          final_d      = 1'b0;
          pos_d        = '0;
          seq_d        = 8'd1;
          att_d        = '0;
          s1_d.crc_clr = 1'b1;
        end else begin
          s1_d.status = StRefused;
        end
      end
      OpData: begin
        if ((phase_q == PhWaitStart || phase_q == PhFill || phase_q == PhDelay)
            && !ready_blk && fill_q < CntW'(BUFFER_BYTES)) begin
          mem_we = 1'b1;
          fill_d = fill_q + CntW'(1);
          if (s_tlast) final_d = 1'b1;
          if (phase_q == PhFill && (s_tlast || final_q || fill_d >= bsize)) begin
            start_pk = 1'b1;
          end
        end else begin
          s1_d.status = StRefused;
        end
      end
      OpRx: begin
        case (phase_q)
          PhWaitStart: begin
            if (s_tdata == ChC) begin
              s1_d.status = StStarted;
              to_fill     = 1'b1;
            end else if (s_tdata == ChNak) begin
              s1_d.status = StCsumRef;
              phase_d     = PhDone;
            end else if (s_tdata == ChCan) begin
              s1_d.status = StCancel;
              phase_d     = PhDone;
            end
          end
          PhWaitResp: begin
            if (s_tdata == ChAck) begin
              s1_d.status = StAcked;
              seq_d       = seq_q + 8'd1;
              att_d       = '0;
              if (final_q) begin
                phase_d = PhEotSend;
              end else begin
                fill_d = '0;
                if (use_1k_q && flash_q != 8'd0) begin
                  phase_d = PhDelay;
                  timer_d = '0;
                end else begin
                  phase_d = PhFill;  // fill empty and not final
                end
              end
            end else if (s_tdata == ChNak) begin
              fail = 1'b1;
            end else if (s_tdata == ChCan) begin
              s1_d.status = StCancel;
              phase_d     = PhDone;
            end
          end
          PhEotWait: begin
            if (s_tdata == ChAck) begin
              s1_d.status = StComplete;
              phase_d     = PhDone;
            end
          end
          default: ;
        endcase
      end
      OpSlot: begin
        if (phase_q == PhSend) begin
          pos_d = pos_q + CntW'(1);
          if (pos_q == CntW'(0)) begin
            s1_d.kind  = KConst;
            s1_d.cbyte = use_1k_q ? ChStx : ChSoh;
          end else if (pos_q == CntW'(1)) begin
            s1_d.kind  = KConst;
            s1_d.cbyte = seq_q;
          end else if (pos_q == CntW'(2)) begin
            s1_d.kind  = KConst;
            s1_d.cbyte = ~seq_q;
          end else if (idx < bsize) begin
            if (idx < fill_q) begin
              s1_d.kind = KMem;
              mem_re    = 1'b1;
            end else begin
              s1_d.kind = KPad;
            end
          end else if (pos_q == bsize + CntW'(3)) begin
            s1_d.kind = KCrcHi;
          end else begin
            s1_d.kind = KCrcLo;
            phase_d   = PhWaitResp;
            timer_d   = '0;
            pos_d     = '0;
          end
        end else if (phase_q == PhEotSend) begin
          s1_d.kind  = KConst;
          s1_d.cbyte = ChEot;
          phase_d    = PhEotWait;
          timer_d    = '0;
        end
      end
      OpTick: begin
        if (phase_q == PhWaitStart || phase_q == PhWaitResp ||
            phase_q == PhEotWait || phase_q == PhDelay) begin
          timer_d = tinc;
          if (phase_q == PhWaitStart) limit = start_to_q;
          else if (phase_q == PhDelay) limit = {8'd0, flash_q};
          if (tinc >= limit) begin
            case (phase_q)
              PhWaitStart: begin
                s1_d.status = StStartTo;
                phase_d     = PhDone;
              end
              PhWaitResp: fail = 1'b1;
              PhEotWait: begin
                s1_d.status = StEotTo;
                phase_d     = PhDone;
              end
              default: to_fill = 1'b1;
            endcase
          end
        end
      end
      default: ;
    endcase

    // Enter the fill phase, or start the packet at once if a block waits.
    if (to_fill) begin
      if (ready_blk) start_pk = 1'b1;
      else phase_d = PhFill;
    end

    // Count a failed attempt; stop at the limit, else resend.
    if (fail) begin
      att_d = (att_q != 8'hFF) ? att_q + 8'd1 : att_q;
      if (att_d >= retries_q) begin
        s1_d.status = StExhaust;
        phase_d     = PhDone;
      end else begin
        s1_d.status = StRetry;
        start_pk    = 1'b1;
      end
    end

    if (start_pk) begin
      phase_d      = PhSend;
      pos_d        = '0;
      s1_d.crc_clr = 1'b1;
    end

    s1_d.seq = seq_d;
    s1_d.att = att_d;
    s1_d.fin = (phase_d == PhDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      fill_q  <= '0;
      final_q <= 1'b0;
      pos_q   <= '0;
      seq_q   <= 8'd1;
      att_q   <= '0;
      timer_q <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      final_q <= final_d;
      pos_q   <= pos_d;
      seq_q   <= seq_d;
      att_q   <= att_d;
      timer_q <= timer_d;
    end
  end

  // ---------------- block memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && mem_we) mem[fill_q[AddrW-1:0]] <= s_tdata;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && mem_re) rdata_q <= mem[rd_addr];
  end

  // ---------------- second stage: pick the byte, advance the CRC
  logic [7:0] byte_c;
  always_comb begin
    case (s1_q.kind)
      KConst:  byte_c = s1_q.cbyte;
      KMem:    byte_c = rdata_q;
      KPad:    byte_c = ChPad;
      KCrcHi:  byte_c = crc_q[15:8];
      KCrcLo:  byte_c = crc_q[7:0];
      default: byte_c = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      crc_q   <= '0;
    end else begin
      if (s_tready) s1_v_q <= in_acc;
      if (adv) begin
        out_v_q <= s1_v_q;
        if (s1_v_q) begin
          if (s1_q.crc_clr) crc_q <= '0;
          else if (s1_q.kind == KMem || s1_q.kind == KPad) crc_q <= crc_step(crc_q, byte_c);
        end
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= s1_d;
    if (adv && s1_v_q) begin
      out_q <= {s1_q.fin, s1_q.att, s1_q.seq, s1_q.status, byte_c,
                (s1_q.kind != KNone)};
    end
  end

  assign m_tvalid = out_v_q;
  assign m_tdata  = {2'b00, out_q};

  `XCS_ASSERT(a_s1_hold, (s1_v_q && !adv) |=> s1_v_q, "stage item lost while stalled")
  `XCS_ASSERT(a_fill_range, fill_q <= CntW'(BUFFER_BYTES), "fill count beyond buffer")
  `XCS_ASSERT(a_rd_in_send, mem_re |-> (phase_q == PhSend),
              "block memory read outside the send phase")
  `XCS_ASSERT(a_ready_rule, s_tready == (!s1_v_q || !out_v_q || m_tready),
              "input ready does not follow pipeline space")
endmodule
`default_nettype wire
